// ===== rtl/first_substring_match_finder_unit_defines.svh =====
`ifndef FIRST_SUBSTRING_MATCH_FINDER_UNIT_DEFINES_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FSMF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fsmf check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define FSMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fsmf check failed");

`endif

// ===== rtl/fsmf_pkg.sv =====
package fsmf_pkg;

	localparam int POS_W  = 31;
	localparam int PLEN_W = 7;
	localparam int BYTE_W = 8;

	localparam logic [1:0] MODE_BEGIN   = 2'd0;
	localparam logic [1:0] MODE_PATTERN = 2'd1;
	localparam logic [1:0] MODE_TEXT    = 2'd2;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} fsmf_result_t;

	typedef struct packed {
		logic pat_shift;
		logic txt_shift;
	} fsmf_cell_ctl_t;

endpackage

// ===== rtl/fsmf_if.sv =====
interface fsmf_item_if import fsmf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [BYTE_W-1:0] data_byte;
	logic [PLEN_W-1:0] pattern_length;
	logic [POS_W-1:0]  text_length;

	modport source(output valid, mode, data_byte, pattern_length, text_length, input ready);
	modport sink(input valid, mode, data_byte, pattern_length, text_length, output ready);
endinterface

interface fsmf_result_if import fsmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source(output valid, found, position, input ready);
	modport sink(input valid, found, position, output ready);
endinterface

// ===== rtl/fsmf_cell.sv =====
module fsmf_cell import fsmf_pkg::*; (
	input  logic              clk,
	input  fsmf_cell_ctl_t    ctl,
	input  logic              used,
	input  logic [BYTE_W-1:0] pat_in,
	input  logic [BYTE_W-1:0] txt_in,
	output logic [BYTE_W-1:0] pat_out,
	output logic [BYTE_W-1:0] txt_out,
	output logic              hit
);

	logic [BYTE_W-1:0] pat_q;
	logic [BYTE_W-1:0] txt_q;

	always_ff @(posedge clk) begin
		if (ctl.pat_shift) begin
			pat_q <= pat_in;
		end
		if (ctl.txt_shift) begin
			txt_q <= txt_in;
		end
	end

	// compare against the byte this cell will hold after the shift
	assign hit     = !used || (pat_q == txt_in);
	assign pat_out = pat_q;
	assign txt_out = txt_q;

endmodule

// ===== rtl/fsmf_out_buf.sv =====
module fsmf_out_buf import fsmf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fsmf_result_t   push_data,
	output logic           full,
	fsmf_result_if.source  result
);

	logic         out_v_q;
	logic         skid_v_q;
	fsmf_result_t out_d_q;
	fsmf_result_t skid_d_q;
	logic         pop;

	assign pop = out_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q  <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
				if (push) begin
					skid_d_q <= push_data;
				end
			end else if (push) begin
				out_d_q <= push_data;
			end
		end else if (push) begin
			skid_d_q <= push_data;
		end
	end

	assign full            = skid_v_q;
	assign result.valid    = out_v_q;
	assign result.found    = out_d_q.found;
	assign result.position = out_d_q.position;

endmodule

// ===== rtl/first_substring_match_finder_unit.sv =====
// first substring match finder
// item channel (sink): mode selects begin, pattern byte or text byte; a begin
// transfer carries pattern_length and text_length, the others carry data_byte.
// result channel (source): found and position, at most one transfer per search.
// pattern bytes and text bytes both run through a row of MAX_PATTERN cells;
// each cell compares its pattern byte with the incoming window byte, so every
// text byte is settled in the cycle it is taken.
// throughput: one item per cycle while item ready is high, any mix of modes.
// result: the result is registered into the output buffer by the transfer
// that settles it (the begin for an empty or too long pattern, else the text
// byte that completes the first match or the last text byte).
// stall: results wait in a two-entry output buffer; item ready drops only while
// both entries are held, and returns as soon as the receiver takes one.
// reset: arst_n clears the search state; no search is open and text or
// pattern bytes are dropped until a begin arrives. no clearing pass is needed.
`include "first_substring_match_finder_unit_defines.svh"

module first_substring_match_finder_unit import fsmf_pkg::*; #(
	parameter int MAX_PATTERN = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	fsmf_item_if.sink     item,
	fsmf_result_if.source result
);

	localparam int PW = $clog2(MAX_PATTERN + 1);
	localparam int CW = (PW > PLEN_W) ? PW : PLEN_W;

	logic [PW-1:0]    pcount_q;
	logic [PW-1:0]    psize_q;
	logic [POS_W-1:0] tsize_q;
	logic [POS_W-1:0] tcount_q;
	logic             decided_q;

	logic             acc;
	logic             full;
	logic [CW-1:0]    plen_ext;
	logic [PW-1:0]    psize_new;
	logic [POS_W-1:0] tcount_inc;
	logic [POS_W-1:0] psize_ext;
	logic             all_hit;
	logic             pat_take;
	logic             txt_take;
	logic             push;
	fsmf_result_t     push_data;
	fsmf_cell_ctl_t   ctl;

	logic [BYTE_W-1:0]      pat_chain [MAX_PATTERN+1];
	logic [BYTE_W-1:0]      txt_chain [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] hits;

	assign item.ready = !full;
	assign acc        = item.valid && item.ready;

	assign plen_ext   = CW'(item.pattern_length);
	assign psize_new  = (plen_ext > CW'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : PW'(plen_ext);
	assign tcount_inc = tcount_q + POS_W'(1);
	assign psize_ext  = POS_W'(psize_q);

	assign pat_take = acc && item.mode == MODE_PATTERN && !decided_q && pcount_q < psize_q;
	assign txt_take = acc && item.mode == MODE_TEXT && !decided_q && pcount_q >= psize_q;

	assign ctl.pat_shift = pat_take;
	assign ctl.txt_shift = txt_take;

	assign pat_chain[0] = item.data_byte;
	assign txt_chain[0] = item.data_byte;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		fsmf_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.used   (PW'(i) < psize_q),
			.pat_in (pat_chain[i]),
			.txt_in (txt_chain[i]),
			.pat_out(pat_chain[i+1]),
			.txt_out(txt_chain[i+1]),
			.hit    (hits[i])
		);
	end

	assign all_hit = &hits;

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (acc) begin
			unique case (item.mode)
				MODE_BEGIN: begin
					if (psize_new == '0) begin
						push            = 1'b1;
						push_data.found = 1'b1;
					end else if (POS_W'(psize_new) > item.text_length) begin
						push = 1'b1;
					end
				end
				MODE_TEXT: begin
					if (txt_take) begin
						if (tcount_inc >= psize_ext && all_hit) begin
							push               = 1'b1;
							push_data.found    = 1'b1;
							push_data.position = tcount_inc - psize_ext;
						end else if (tcount_inc >= tsize_q) begin
							push = 1'b1;
						end
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= '0;
			psize_q   <= '0;
			tsize_q   <= '0;
			tcount_q  <= '0;
			decided_q <= 1'b1;
		end else if (acc && item.mode == MODE_BEGIN) begin
			psize_q   <= psize_new;
			tsize_q   <= item.text_length;
			pcount_q  <= '0;
			tcount_q  <= '0;
			decided_q <= push;
		end else begin
			if (pat_take) begin
				pcount_q <= pcount_q + PW'(1);
			end
			if (txt_take) begin
				tcount_q <= tcount_inc;
				if (push) begin
					decided_q <= 1'b1;
				end
			end
		end
	end

	fsmf_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.result   (result)
	);

	`FSMF_ASSERT_NOW(a_pcount_bound, 1'b1, pcount_q <= psize_q)
	`FSMF_ASSERT_NOW(a_psize_bound, 1'b1, psize_q <= PW'(MAX_PATTERN))
	`FSMF_ASSERT_NOW(a_miss_pos_zero, result.valid && !result.found, result.position == '0)
	`FSMF_ASSERT_NEXT(a_settle_closes, txt_take && push, decided_q)

endmodule
